// ===== design/gmcn_pkg.sv =====
// Shared types, widths and constants of the grid corner-normal block.
`timescale 1ns / 1ps
package gmcn_pkg;
    localparam int POS_W  = 24;
    localparam int DIF_W  = 25;
    localparam int PRD_W  = 50;
    localparam int CRS_W  = 51;
    localparam int RED_W  = 30;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 64;
    localparam int LEN_W  = 32;
    localparam int NUM_W  = 45;
    localparam int QUO_W  = 15;
    localparam int FRAC_W = 14;
    localparam int NRM_W  = 16;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 4096;

    localparam int CFG_W  = 13;
    localparam int WCFG_W = 7;
    localparam int LCFG_W = 13;
    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 7'd35;
    localparam logic [LCFG_W-1:0] LENGTH_RESET = 13'd50;
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_LENGTH = 1'b1;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    localparam logic signed [NRM_W-1:0] ONE_FIX = 16'sd16384;

    typedef struct packed {
        logic [POS_W-1:0] z;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } t_pos;

    typedef struct packed {
        logic signed [DIF_W-1:0] x;
        logic signed [DIF_W-1:0] y;
        logic signed [DIF_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_norm;

    typedef struct packed {
        logic start;
        t_vec a;
        t_vec b;
    } t_unit_req;

    function automatic t_vec vdiff(t_pos a, t_pos b);
        t_vec r;
        r.x = DIF_W'($signed(a.x)) - DIF_W'($signed(b.x));
        r.y = DIF_W'($signed(a.y)) - DIF_W'($signed(b.y));
        r.z = DIF_W'($signed(a.z)) - DIF_W'($signed(b.z));
        return r;
    endfunction
endpackage

// ===== design/gmcn_lines.sv =====
// Two line stores holding the previous and the current grid row.
`timescale 1ns / 1ps
module gmcn_lines #(
    parameter int MAX_COLS = gmcn_pkg::DEF_MAX_COLS
) (
    input  logic                        i_clk,
    input  logic [$clog2(MAX_COLS)-1:0] i_rd_c_addr,
    input  logic [$clog2(MAX_COLS)-1:0] i_rd_a_addr,
    output gmcn_pkg::t_pos              o_rd_c,
    output gmcn_pkg::t_pos              o_rd_a,
    input  logic                        i_we,
    input  logic [$clog2(MAX_COLS)-1:0] i_wr_addr,
    input  gmcn_pkg::t_pos              i_wr_c,
    input  gmcn_pkg::t_pos              i_wr_a
);
    import gmcn_pkg::*;

    t_pos r_center [MAX_COLS];
    t_pos r_above  [MAX_COLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_center[i_wr_addr] <= i_wr_c;
            r_above[i_wr_addr]  <= i_wr_a;
        end
        o_rd_c <= r_center[i_rd_c_addr];
        o_rd_a <= r_above[i_rd_a_addr];
    end
endmodule

// ===== design/gmcn_unit.sv =====
// Cross product and fixed-point normalisation, one step of work per cycle.
`timescale 1ns / 1ps
module gmcn_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gmcn_pkg::t_unit_req i_req,
    output logic                o_done,
    output gmcn_pkg::t_norm     o_norm
);
    import gmcn_pkg::*;

    typedef enum logic [9:0] {
        U_IDLE  = 10'b0000000001,
        U_MUL   = 10'b0000000010,
        U_SUB   = 10'b0000000100,
        U_MAG   = 10'b0000001000,
        U_SHIFT = 10'b0000010000,
        U_SQ    = 10'b0000100000,
        U_ROOT  = 10'b0001000000,
        U_LOAD  = 10'b0010000000,
        U_DIV   = 10'b0100000000,
        U_DONE  = 10'b1000000000
    } t_ustate;

    t_ustate r_state;
    t_vec    r_a, r_b;
    logic [2:0] r_step;
    logic signed [PRD_W-1:0] r_p [6];
    logic signed [CRS_W-1:0] r_c [3];
    logic [CRS_W-1:0]  r_m [3];
    logic [2:0]        r_neg;
    logic [SUM_W-1:0]  r_sum;
    logic [ROOT_W-1:0] r_v, r_res, r_bit;
    logic [LEN_W-1:0]  r_len, r_rem;
    logic [QUO_W-1:0]  r_num, r_q;
    logic [1:0]        r_comp;
    logic [3:0]        r_dk;
    t_norm             r_out;

    logic signed [DIF_W-1:0] w_ml, w_mr;
    logic signed [PRD_W-1:0] w_prod;
    logic [2*RED_W-1:0] w_sq;
    logic [SUM_W-1:0]   w_sum_n;
    logic [ROOT_W-1:0]  w_trial, w_res_n;
    logic               w_rge, w_big, w_czero, w_dge;
    logic [LEN_W-1:0]   w_t;
    logic [NUM_W-1:0]   w_n;
    logic [QUO_W-1:0]   w_q_n;
    logic signed [NRM_W-1:0] w_comp;

    always_comb begin
        unique case (r_step)
            3'd0: begin w_ml = r_a.y; w_mr = r_b.z; end
            3'd1: begin w_ml = r_a.z; w_mr = r_b.y; end
            3'd2: begin w_ml = r_a.z; w_mr = r_b.x; end
            3'd3: begin w_ml = r_a.x; w_mr = r_b.z; end
            3'd4: begin w_ml = r_a.x; w_mr = r_b.y; end
            3'd5: begin w_ml = r_a.y; w_mr = r_b.x; end
            default: begin w_ml = '0; w_mr = '0; end
        endcase
    end

    assign w_prod  = w_ml * w_mr;
    assign w_sq    = r_m[r_step[1:0]][RED_W-1:0] * r_m[r_step[1:0]][RED_W-1:0];
    assign w_sum_n = r_sum + SUM_W'(w_sq);
    assign w_trial = r_res + r_bit;
    assign w_rge   = r_v >= w_trial;
    assign w_res_n = w_rge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign w_big   = (|r_m[0][CRS_W-1:RED_W]) | (|r_m[1][CRS_W-1:RED_W])
                   | (|r_m[2][CRS_W-1:RED_W]);
    assign w_czero = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    assign w_n     = NUM_W'({r_m[r_comp][RED_W-1:0], {FRAC_W{1'b0}}})
                   + NUM_W'(r_len >> 1);
    assign w_t     = {r_rem[LEN_W-2:0], r_num[QUO_W-1]};
    assign w_dge   = w_t >= r_len;
    assign w_q_n   = {r_q[QUO_W-2:0], w_dge};
    assign w_comp  = r_neg[r_comp] ? -$signed({1'b0, w_q_n}) : $signed({1'b0, w_q_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            unique case (r_state)
                U_IDLE:  if (i_req.start) r_state <= U_MUL;
                U_MUL:   if (r_step == 3'd5) r_state <= U_SUB;
                U_SUB:   r_state <= U_MAG;
                U_MAG:   r_state <= w_czero ? U_DONE : U_SHIFT;
                U_SHIFT: if (!w_big) r_state <= U_SQ;
                U_SQ:    if (r_step == 3'd2) r_state <= U_ROOT;
                U_ROOT:  if (r_bit[0]) r_state <= U_LOAD;
                U_LOAD:  r_state <= U_DIV;
                U_DIV: begin
                    if (r_dk == 4'(QUO_W - 1)) r_state <= (r_comp == 2'd2) ? U_DONE : U_LOAD;
                end
                U_DONE:  r_state <= U_IDLE;
                default: r_state <= U_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_step <= '0;
            end
            U_MUL: begin
                r_p[r_step] <= w_prod;
                r_step      <= r_step + 3'd1;
            end
            U_SUB: begin
                r_c[0] <= CRS_W'(r_p[0]) - CRS_W'(r_p[1]);
                r_c[1] <= CRS_W'(r_p[2]) - CRS_W'(r_p[3]);
                r_c[2] <= CRS_W'(r_p[4]) - CRS_W'(r_p[5]);
            end
            U_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_c[i][CRS_W-1];
                    r_m[i]   <= r_c[i][CRS_W-1] ? CRS_W'(-r_c[i]) : CRS_W'(r_c[i]);
                end
                if (w_czero) r_out <= '{x: '0, y: ONE_FIX, z: '0};
            end
            U_SHIFT: begin
                if (w_big) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end else begin
                    r_step <= '0;
                    r_sum  <= '0;
                end
            end
            U_SQ: begin
                r_sum  <= w_sum_n;
                r_step <= r_step + 3'd1;
                r_v    <= ROOT_W'(w_sum_n);
                r_res  <= '0;
                r_bit  <= ROOT_W'(1) << (SUM_W - 0);
            end
            U_ROOT: begin
                if (w_rge) r_v <= r_v - w_trial;
                r_res  <= w_res_n;
                r_bit  <= r_bit >> 2;
                r_len  <= w_res_n[LEN_W-1:0];
                r_comp <= '0;
            end
            U_LOAD: begin
                r_rem <= LEN_W'(w_n[NUM_W-1:QUO_W]);
                r_num <= w_n[QUO_W-1:0];
                r_q   <= '0;
                r_dk  <= '0;
            end
            U_DIV: begin
                r_rem <= w_dge ? (w_t - r_len) : w_t;
                r_num <= r_num << 1;
                r_q   <= w_q_n;
                r_dk  <= r_dk + 4'd1;
                if (r_dk == 4'(QUO_W - 1)) begin
                    r_comp <= r_comp + 2'd1;
                    unique case (r_comp)
                        2'd0:    r_out.x <= w_comp;
                        2'd1:    r_out.y <= w_comp;
                        default: r_out.z <= w_comp;
                    endcase
                end
            end
            U_DONE: ;
            default: ;
        endcase
    end

    assign o_done = (r_state == U_DONE);
    assign o_norm = r_out;
endmodule

// ===== design/grid_mesh_corner_normals.sv =====
// Top level: stream control, line stores and sequencing of the corner normals.
`timescale 1ns / 1ps
// Grid vertices arrive in raster order, one per input transaction, and each
// transaction of the result stream carries one corner normal of one grid point.
// An item on row 0 gives the four border normals of that point at once; an
// item on row 2 or later gives the four normals of the point above it, and an
// item on the last row also gives its own four border normals. The block
// works on one item at a time. The previous two rows live in two line
// memories with a registered read, read in states RD1, RD2 and RD3 and
// written back at the end of that read phase. Each interior corner goes
// through one shared normalisation unit: six sequential 25x25 products, a
// shift to bring the cross product below 2^30, three squares, a 32-step
// square root and three 15-step divisions. Writing either configuration
// register restarts the grid at row 0, column 0.
module grid_mesh_corner_normals #(
    parameter int MAX_COLS = gmcn_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gmcn_pkg::DEF_MAX_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [gmcn_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // pos_x [23:0], pos_y [47:24], pos_z [71:48]
    input  logic [71:0]                i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // cell_col [5:0], cell_row [17:6], norm_x [33:18], norm_y [49:34],
    // norm_z [65:50], zero [71:66]
    output logic [71:0]                o_m_axis_tdata,
    // corner [1:0]
    output logic [1:0]                 o_m_axis_tuser,
    // run_last
    output logic                       o_m_axis_tlast
);
    import gmcn_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    typedef enum logic [6:0] {
        T_IDLE = 7'b0000001,
        T_RD1  = 7'b0000010,
        T_RD2  = 7'b0000100,
        T_RD3  = 7'b0001000,
        T_CALC = 7'b0010000,
        T_WAIT = 7'b0100000,
        T_EMIT = 7'b1000000
    } t_state;

    t_state r_state;
    logic [WCFG_W-1:0] r_cfg_w;
    logic [LCFG_W-1:0] r_cfg_l;
    logic [CW-1:0] r_col, r_x;
    logic [RW-1:0] r_row, r_z;
    t_pos  r_cur, r_here, r_below;
    t_vec  r_up, r_dn, r_rt, r_lf;
    logic  r_interior, r_first, r_second, r_phase;
    logic [1:0] r_corner;
    t_norm r_nrm;

    logic        r_ovalid, r_olast;
    logic [5:0]  r_ocol;
    logic [11:0] r_orow;
    logic [1:0]  r_ocorner;
    t_norm       r_onorm;

    logic [CW:0] w_w, w_x1;
    logic [RW:0] w_l, w_z1;
    logic [CW-1:0] w_x;
    logic [RW-1:0] w_z;
    logic w_in_acc, w_free, w_load, w_unit_done;
    logic [CW-1:0] w_rd_c_addr, w_rd_a_addr;
    t_pos  w_rd_c, w_rd_a;
    t_unit_req w_req;
    t_norm w_unit_norm;

    // Registers are used clamped to the supported grid size.
    always_comb begin
        if (r_cfg_w < WCFG_W'(3))                  w_w = (CW+1)'(3);
        else if (32'(r_cfg_w) > MAX_COLS)          w_w = (CW+1)'(MAX_COLS);
        else                                       w_w = (CW+1)'(r_cfg_w);
        if (r_cfg_l < LCFG_W'(3))                  w_l = (RW+1)'(3);
        else if (32'(r_cfg_l) > MAX_ROWS)          w_l = (RW+1)'(MAX_ROWS);
        else                                       w_l = (RW+1)'(r_cfg_l);
    end

    assign w_x  = ((CW+1)'(r_col) >= w_w) ? '0 : r_col;
    assign w_z  = ((RW+1)'(r_row) >= w_l) ? '0 : r_row;
    assign w_x1 = (CW+1)'(w_x) + (CW+1)'(1);
    assign w_z1 = (RW+1)'(w_z) + (RW+1)'(1);

    assign o_s_axis_tready = (r_state == T_IDLE);
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_free   = !r_ovalid || i_m_axis_tready;
    assign w_load   = (r_state == T_EMIT) && w_free;

    // First read fetches the point itself from both rows; the second its
    // right neighbour in the stored row and the already refreshed left one.
    assign w_rd_c_addr = (r_state == T_RD1) ? r_x : r_x + CW'(1);
    assign w_rd_a_addr = (r_state == T_RD1) ? r_x : r_x - CW'(1);

    gmcn_lines #(.MAX_COLS(MAX_COLS)) u_lines (
        .i_clk       (i_clk),
        .i_rd_c_addr (w_rd_c_addr),
        .i_rd_a_addr (w_rd_a_addr),
        .o_rd_c      (w_rd_c),
        .o_rd_a      (w_rd_a),
        .i_we        (r_state == T_RD3),
        .i_wr_addr   (r_x),
        .i_wr_c      (r_cur),
        .i_wr_a      (r_here)
    );

    always_comb begin
        w_req.start = (r_state == T_CALC) && !r_phase && r_interior;
        unique case (r_corner)
            CORNER_TL: begin w_req.a = r_up; w_req.b = r_lf; end
            CORNER_TR: begin w_req.a = r_rt; w_req.b = r_up; end
            CORNER_BL: begin w_req.a = r_lf; w_req.b = r_dn; end
            CORNER_BR: begin w_req.a = r_dn; w_req.b = r_rt; end
            default:   begin w_req.a = r_up; w_req.b = r_lf; end
        endcase
    end

    gmcn_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_unit_done),
        .o_norm  (w_unit_norm)
    );

    // Sequencer and grid position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_cfg_w <= WIDTH_RESET;
            r_cfg_l <= LENGTH_RESET;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_GRID_WIDTH:  r_cfg_w <= i_cfg_data[WCFG_W-1:0];
                    CFG_GRID_LENGTH: r_cfg_l <= i_cfg_data[LCFG_W-1:0];
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (w_in_acc) begin
                if (w_x1 >= w_w) begin
                    r_col <= '0;
                    r_row <= (w_z1 >= w_l) ? '0 : RW'(w_z1);
                end else begin
                    r_col <= CW'(w_x1);
                    r_row <= w_z;
                end
            end
            unique case (r_state)
                T_IDLE: if (w_in_acc) r_state <= T_RD1;
                T_RD1:  r_state <= T_RD2;
                T_RD2:  r_state <= T_RD3;
                T_RD3:  r_state <= (r_first || r_second) ? T_CALC : T_IDLE;
                T_CALC: r_state <= w_req.start ? T_WAIT : T_EMIT;
                T_WAIT: if (w_unit_done) r_state <= T_EMIT;
                T_EMIT: begin
                    if (w_free) begin
                        if (r_corner != CORNER_BR) r_state <= T_CALC;
                        else if (!r_phase && r_second) r_state <= T_CALC;
                        else r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // Item data path.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            T_IDLE: begin
                r_cur      <= i_s_axis_tdata;
                r_x        <= w_x;
                r_z        <= w_z;
                r_first    <= (w_z == '0) || (w_z >= RW'(2));
                r_second   <= (w_z1 == w_l);
                r_interior <= (w_z >= RW'(2)) && (w_x != '0) && (w_x1 < w_w);
                r_corner   <= CORNER_TL;
            end
            T_RD1: ;
            T_RD2: begin
                r_here  <= w_rd_c;
                r_below <= w_rd_a;
            end
            T_RD3: begin
                r_up    <= vdiff(r_cur, r_here);
                r_dn    <= vdiff(r_below, r_here);
                r_rt    <= vdiff(w_rd_c, r_here);
                r_lf    <= vdiff(w_rd_a, r_here);
                r_phase <= !r_first;
            end
            T_CALC: begin
                r_nrm <= '{x: '0, y: ONE_FIX, z: '0};
            end
            T_WAIT: begin
                if (w_unit_done) r_nrm <= w_unit_norm;
            end
            T_EMIT: begin
                if (w_free) begin
                    r_corner <= r_corner + 2'd1;
                    if (r_corner == CORNER_BR) r_phase <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register: a finished result waits here while the sequencer
    // moves on or returns to accept the next vertex.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ocol    <= 6'(r_x);
            r_orow    <= r_phase ? 12'(r_z) : ((r_z == '0) ? '0 : 12'(r_z - RW'(1)));
            r_ocorner <= r_corner;
            r_onorm   <= r_nrm;
            r_olast   <= (r_corner == CORNER_BR) && (r_phase || !r_second);
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'b0, r_onorm.z, r_onorm.y, r_onorm.x, r_orow, r_ocol};
    assign o_m_axis_tuser  = r_ocorner;
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTH
    a_unit_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_unit_done |-> (r_state == T_WAIT))
        else $error("normalisation finished while the sequencer was not waiting");

    a_last_is_corner3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser == CORNER_BR))
        else $error("run end flagged on a corner other than bottom-right");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_axis_tready)
        else $error("a second vertex was taken before the first was processed");
`endif
endmodule

// ===== tb/tb_grid_mesh_corner_normals.sv =====
// Self-checking testbench for the grid corner-normal block.
`timescale 1ns / 1ps
module tb_grid_mesh_corner_normals;
    import gmcn_pkg::*;

    // A settled wait after the last result. The block may still be storing a
    // row-1 vertex, which gives no result.
    localparam int SETTLE_CYCLES = 700;

    typedef struct packed {
        logic [5:0]  col;
        logic [11:0] row;
        logic [1:0]  corner;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        last;
    } t_normal_item;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = CFG_GRID_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    grid_mesh_corner_normals DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Predicted state of the block: both line stores, the counters and the
    // two registers as written.
    t_point older_row[DEF_MAX_COLS];
    t_point newer_row[DEF_MAX_COLS];
    int unsigned next_col;
    int unsigned next_row;
    int unsigned width_reg;
    int unsigned length_reg;

    t_normal_item pending_normals[$];
    int errors = 0;
    int vertices_sent = 0;
    bit calm = 1'b0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Cross product a x b, reduced to a unit vector with 14 fraction bits.
    // A degenerate product points straight up.
    function automatic t_point unit_cross(t_point a, t_point b);
        longint c[3];
        longint unsigned m[3];
        longint unsigned top;
        longint unsigned total;
        longint unsigned len;
        longint unsigned q;
        int sh;
        t_point r;
        c[0] = a.y * b.z - a.z * b.y;
        c[1] = a.z * b.x - a.x * b.z;
        c[2] = a.x * b.y - a.y * b.x;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? -c[i] : c[i];
            if (m[i] > top) top = m[i];
        end
        if (top == 0) begin
            r.x = 0;
            r.y = 16384;
            r.z = 0;
            return r;
        end
        sh = 0;
        while ((top >> sh) >= (64'd1 << 30)) sh++;
        total = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= sh;
            total += m[i] * m[i];
        end
        len = root_floor(total);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            c[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        r.x = c[0];
        r.y = c[1];
        r.z = c[2];
        return r;
    endfunction

    function automatic t_point pdiff(t_point a, t_point b);
        t_point r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic void queue_normal(int unsigned col, int unsigned row,
                                         logic [1:0] corner, t_point n);
        t_normal_item e;
        e.col = col[5:0];
        e.row = row[11:0];
        e.corner = corner;
        e.nx = n.x[15:0];
        e.ny = n.y[15:0];
        e.nz = n.z[15:0];
        e.last = 1'b0;
        pending_normals.push_back(e);
    endfunction

    function automatic void queue_border(int unsigned col, int unsigned row);
        t_point up;
        up.x = 0;
        up.y = 16384;
        up.z = 0;
        queue_normal(col, row, CORNER_TL, up);
        queue_normal(col, row, CORNER_TR, up);
        queue_normal(col, row, CORNER_BL, up);
        queue_normal(col, row, CORNER_BR, up);
    endfunction

    // Works out the normals caused by one accepted vertex and advances the
    // predicted raster position.
    function automatic void predict_vertex(logic [71:0] data);
        int unsigned w;
        int unsigned l;
        int unsigned x;
        int unsigned z;
        int before_count;
        t_point cur;
        t_point up;
        t_point down;
        t_point rt;
        t_point lf;
        w = (width_reg < 3) ? 3 : (width_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : width_reg;
        l = (length_reg < 3) ? 3 : (length_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : length_reg;
        x = (next_col >= w) ? 0 : next_col;
        z = (next_row >= l) ? 0 : next_row;
        cur.x = longint'($signed(data[23:0]));
        cur.y = longint'($signed(data[47:24]));
        cur.z = longint'($signed(data[71:48]));
        before_count = pending_normals.size();
        if (z == 0) begin
            queue_border(x, 0);
        end else if (z >= 2) begin
            if (x >= 1 && x + 1 < w) begin
                up = pdiff(cur, newer_row[x]);
                down = pdiff(older_row[x], newer_row[x]);
                rt = pdiff(newer_row[x+1], newer_row[x]);
                lf = pdiff(older_row[x-1], newer_row[x]);
                queue_normal(x, z - 1, CORNER_TL, unit_cross(up, lf));
                queue_normal(x, z - 1, CORNER_TR, unit_cross(rt, up));
                queue_normal(x, z - 1, CORNER_BL, unit_cross(lf, down));
                queue_normal(x, z - 1, CORNER_BR, unit_cross(down, rt));
            end else begin
                queue_border(x, z - 1);
            end
        end
        if (z + 1 == l) queue_border(x, z);
        if (pending_normals.size() > before_count)
            pending_normals[pending_normals.size()-1].last = 1'b1;
        older_row[x] = newer_row[x];
        newer_row[x] = cur;
        x++;
        if (x >= w) begin
            x = 0;
            z++;
            if (z >= l) z = 0;
        end
        next_col = x;
        next_row = z;
    endfunction

    // Checks every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_normal_item got;
        t_normal_item want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.col = o_m_axis_tdata[5:0];
            got.row = o_m_axis_tdata[17:6];
            got.corner = o_m_axis_tuser;
            got.nx = o_m_axis_tdata[33:18];
            got.ny = o_m_axis_tdata[49:34];
            got.nz = o_m_axis_tdata[65:50];
            got.last = o_m_axis_tlast;
            if (pending_normals.size() == 0) begin
                $error("unexpected normal: col %0d row %0d corner %0d",
                       got.col, got.row, got.corner);
                errors++;
            end else begin
                want = pending_normals.pop_front();
                if (got.col !== want.col) begin
                    $error("cell_col: expected %0d, got %0d", want.col, got.col);
                    errors++;
                end
                if (got.row !== want.row) begin
                    $error("cell_row: expected %0d, got %0d", want.row, got.row);
                    errors++;
                end
                if (got.corner !== want.corner) begin
                    $error("corner: expected %0d, got %0d", want.corner, got.corner);
                    errors++;
                end
                if (got.nx !== want.nx) begin
                    $error("norm_x: expected %0d, got %0d",
                           $signed(want.nx), $signed(got.nx));
                    errors++;
                end
                if (got.ny !== want.ny) begin
                    $error("norm_y: expected %0d, got %0d",
                           $signed(want.ny), $signed(got.ny));
                    errors++;
                end
                if (got.nz !== want.nz) begin
                    $error("norm_z: expected %0d, got %0d",
                           $signed(want.nz), $signed(got.nz));
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure: random stalls, none once the run has gone calm.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 11) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
        end
    end

    // Called at a falling edge; leaves the testbench at a falling edge.
    task automatic send_vertex(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {pz, py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_vertex(i_s_axis_tdata);
        vertices_sent++;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every predicted normal has arrived and the
    // block has had time to finish any item that gives no result.
    task automatic drain_all();
        i_s_axis_tvalid = 1'b0;
        while (pending_normals.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic addr, int unsigned value);
        drain_all();
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (addr == CFG_GRID_WIDTH) width_reg = value & 7'h7F;
        else length_reg = value & 13'h1FFF;
        next_col = 0;
        next_row = 0;
    endtask

    // A plausible terrain vertex: regular x/z spacing with jitter, random
    // height; now and then any 24-bit value at all.
    task automatic send_terrain(int unsigned col, int unsigned row);
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] pz;
        if ($urandom_range(0, 9) == 0) begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
        end else begin
            px = 24'(int'(col) * 512 + $urandom_range(0, 128) - 64);
            py = 24'(int'($urandom_range(0, 8000)) - 4000);
            pz = 24'(int'(row) * 512 + $urandom_range(0, 128) - 64);
        end
        send_vertex(px, py, pz);
    endtask

    // Smallest grid with every vertex at one place: the interior point sees
    // only zero-length cross products. Also the clamp of too-small registers.
    task automatic test_flat_grid();
        write_reg(CFG_GRID_WIDTH, 0);
        write_reg(CFG_GRID_LENGTH, 1);
        for (int i = 0; i < 9; i++) send_vertex(24'h000100, 24'h000100, 24'h000100);
    endtask

    // Field extremes on a 3x3 grid, so the interior point takes the largest
    // vectors the fields allow.
    task automatic test_extreme_grid();
        logic [23:0] hi;
        logic [23:0] lo;
        hi = 24'h7FFFFF;
        lo = 24'h800000;
        write_reg(CFG_GRID_WIDTH, 3);
        write_reg(CFG_GRID_LENGTH, 3);
        send_vertex(lo, lo, lo);
        send_vertex(hi, lo, hi);
        send_vertex(lo, hi, lo);
        send_vertex(hi, hi, lo);
        send_vertex(24'h0, 24'h0, 24'h0);
        send_vertex(lo, lo, hi);
        send_vertex(lo, hi, hi);
        send_vertex(hi, lo, lo);
        send_vertex(24'hFFFFFF, 24'h000001, 24'hFFFFFF);
    endtask

    // Random grids, mostly small and completed, with register writes between
    // them at the extremes as well. Large values are written but their grids
    // are only begun, since a full one would be far too long.
    task automatic test_random_grids(int unsigned target);
        int unsigned w;
        int unsigned l;
        int unsigned rows_to_send;
        int unsigned pick;
        while (vertices_sent < target) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0: w = 64;
                1: w = 127;
                2: w = $urandom_range(0, 2);
                default: w = $urandom_range(3, 8);
            endcase
            pick = $urandom_range(0, 19);
            case (pick)
                0: l = 4096;
                1: l = 8191;
                2: l = $urandom_range(0, 2);
                default: l = $urandom_range(3, 6);
            endcase
            write_reg(CFG_GRID_WIDTH, w);
            write_reg(CFG_GRID_LENGTH, l);
            w = (w < 3) ? 3 : (w > DEF_MAX_COLS) ? DEF_MAX_COLS : w;
            l = (l < 3) ? 3 : (l > DEF_MAX_ROWS) ? DEF_MAX_ROWS : l;
            rows_to_send = (l > 6) ? 3 : l + $urandom_range(0, 1);
            if (w == DEF_MAX_COLS) rows_to_send = 3;
            for (int r = 0; r < rows_to_send && vertices_sent < target; r++)
                for (int c = 0; c < w && vertices_sent < target; c++)
                    send_terrain(c, r % l);
        end
    endtask

    initial begin
        width_reg = WIDTH_RESET;
        length_reg = LENGTH_RESET;
        next_col = 0;
        next_row = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The default 35-column grid after reset: a few row-0 points.
        for (int c = 0; c < 5; c++) send_terrain(c, 0);
        test_flat_grid();
        test_extreme_grid();
        test_random_grids(330);
        calm = 1'b1;
        test_random_grids(420);

        i_s_axis_tvalid = 1'b0;
        while (pending_normals.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("tb_grid_mesh_corner_normals: PASS");
        else
            $display("tb_grid_mesh_corner_normals: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #80_000_000;
        $display("tb_grid_mesh_corner_normals: FAIL");
        $finish;
    end
endmodule
